// ----- sv/mqtt_publish_line_parser_macros.svh -----
// Assertion helpers used by the parser module mqpl_parse.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef MQTT_PUBLISH_LINE_PARSER_MACROS_SVH
`define MQTT_PUBLISH_LINE_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MQPL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MQPL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/mqpl_pkg.sv -----
`default_nettype none

package mqpl_pkg;

	// Line status codes.
	typedef enum logic [1:0] {
		ST_COMPLETE    = 2'd0,
		ST_FRAGMENTED  = 2'd1,
		ST_NOT_PUBLISH = 2'd2,
		ST_INVALID     = 2'd3
	} status_t;

	// Parser phases, one-hot; each phase sits one bit above its predecessor.
	typedef enum logic [20:0] {
		PH_PREFIX     = 21'h000001,
		PH_KIND_OPEN  = 21'h000002,
		PH_KIND_BODY  = 21'h000004,
		PH_C_KIND     = 21'h000008,
		PH_N1_PRE     = 21'h000010,
		PH_N1_DIG     = 21'h000020,
		PH_C_N1       = 21'h000040,
		PH_N2_PRE     = 21'h000080,
		PH_N2_DIG     = 21'h000100,
		PH_C_N2       = 21'h000200,
		PH_T_OPEN     = 21'h000400,
		PH_T_BODY     = 21'h000800,
		PH_C_T        = 21'h001000,
		PH_N3_PRE     = 21'h002000,
		PH_N3_DIG     = 21'h004000,
		PH_C_N3       = 21'h008000,
		PH_N4_PRE     = 21'h010000,
		PH_N4_DIG     = 21'h020000,
		PH_C_N4       = 21'h040000,
		PH_PAYLOAD_WS = 21'h080000,
		PH_PAYLOAD    = 21'h100000
	} phase_t;

	// One result per line.
	typedef struct packed {
		status_t     status;
		logic [15:0] topic_offset;
		logic [7:0]  topic_size;
		logic [15:0] payload_offset;
		logic [15:0] payload_size;
		logic [31:0] total_size;
	} result_t;

	localparam logic [7:0]  CH_QUOTE   = 8'h22;
	localparam logic [7:0]  CH_COMMA   = 8'h2C;
	localparam logic [7:0]  CH_BSLASH  = 8'h5C;
	localparam logic [7:0]  CH_SPACE   = 8'h20;
	localparam logic [7:0]  CH_TAB     = 8'h09;
	localparam logic [7:0]  CH_CR      = 8'h0D;
	localparam logic [7:0]  CH_LF      = 8'h0A;
	localparam logic [15:0] PREFIX_LAST = 16'd8;
	localparam logic [15:0] MIN_LINE    = 16'd9;
	localparam logic [3:0]  KIND_LEN    = 4'd7;
	localparam logic [31:0] NUM_LIMIT   = 32'd429496729;
	localparam logic [3:0]  NUM_LIMIT_DIGIT = 4'd5;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic bad_quoted(input logic [7:0] b);
		return (b == CH_BSLASH) || (b < CH_SPACE);
	endfunction

	// Characters of "+MQTTURC:".
	function automatic logic [7:0] prefix_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0: c = 8'h2B;
			4'd1: c = 8'h4D;
			4'd2: c = 8'h51;
			4'd3: c = 8'h54;
			4'd4: c = 8'h54;
			4'd5: c = 8'h55;
			4'd6: c = 8'h52;
			4'd7: c = 8'h43;
			4'd8: c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Characters of "publish".
	function automatic logic [7:0] kind_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0: c = 8'h70;
			4'd1: c = 8'h75;
			4'd2: c = 8'h62;
			4'd3: c = 8'h6C;
			4'd4: c = 8'h69;
			4'd5: c = 8'h73;
			4'd6: c = 8'h68;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/mqpl_parse.sv -----
`default_nettype none
`include "mqtt_publish_line_parser_macros.svh"

module mqpl_parse
	import mqpl_pkg::*;
#(
	parameter int MAX_LINE_BYTES = 65535
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] line_byte,
	input  wire logic       end_of_line,
	output result_t         result
);

	localparam logic [15:0] MaxLine = 16'(MAX_LINE_BYTES);

	phase_t      phase_q, phase_d;
	logic [15:0] byte_index_q, byte_index_d;
	logic [3:0]  match_pos_q, match_pos_d;
	logic        kind_mismatch_q, kind_mismatch_d;
	logic [1:0]  first_error_q, first_error_d;
	logic [31:0] number_acc_q, number_acc_d;
	logic [31:0] total_acc_q, total_acc_d;
	logic [31:0] chunk_acc_q, chunk_acc_d;
	logic [15:0] topic_start_q, topic_start_d;
	logic [8:0]  topic_count_q, topic_count_d;
	logic [15:0] payload_start_q, payload_start_d;
	logic [15:0] payload_count_q, payload_count_d;
	logic [15:0] crlf_run_q, crlf_run_d;
	logic        overlong_q, overlong_d;

	logic [15:0] idx;
	logic [15:0] p_size;
	logic [15:0] p_off;

	// State update for one byte of the line.
	always_comb begin
		phase_d         = phase_q;
		byte_index_d    = byte_index_q;
		match_pos_d     = match_pos_q;
		kind_mismatch_d = kind_mismatch_q;
		first_error_d   = first_error_q;
		number_acc_d    = number_acc_q;
		total_acc_d     = total_acc_q;
		chunk_acc_d     = chunk_acc_q;
		topic_start_d   = topic_start_q;
		topic_count_d   = topic_count_q;
		payload_start_d = payload_start_q;
		payload_count_d = payload_count_q;
		crlf_run_d      = crlf_run_q;
		overlong_d      = overlong_q;
		idx             = byte_index_q;

		if (byte_index_q >= MaxLine) begin
			overlong_d = 1'b1;
		end else begin
			byte_index_d = byte_index_q + 16'd1;
			if ((line_byte == CH_CR) || (line_byte == CH_LF)) begin
				crlf_run_d = crlf_run_q + 16'd1;
			end else begin
				crlf_run_d = 16'd0;
			end
			if (first_error_q == 2'd0) begin
				unique case (phase_q) inside
					PH_PREFIX: begin
						if ((idx > PREFIX_LAST) || (line_byte != prefix_char(idx[3:0]))) begin
							first_error_d = ST_NOT_PUBLISH;
						end else if (idx == PREFIX_LAST) begin
							phase_d = PH_KIND_OPEN;
						end
					end
					PH_KIND_OPEN, PH_T_OPEN: begin
						if (!is_ws(line_byte)) begin
							if (line_byte != CH_QUOTE) begin
								first_error_d = ST_INVALID;
							end else begin
								if (phase_q == PH_T_OPEN) begin
									topic_start_d = idx + 16'd1;
									topic_count_d = 9'd0;
								end
								phase_d = phase_t'(phase_q << 1);
							end
						end
					end
					PH_KIND_BODY: begin
						if (line_byte == CH_QUOTE) begin
							if (kind_mismatch_q || (match_pos_q != KIND_LEN)) begin
								first_error_d = ST_NOT_PUBLISH;
							end else begin
								phase_d = PH_C_KIND;
							end
						end else if (bad_quoted(line_byte)) begin
							first_error_d = ST_INVALID;
						end else begin
							if ((match_pos_q >= KIND_LEN) ||
							    (line_byte != kind_char(match_pos_q))) begin
								kind_mismatch_d = 1'b1;
							end
							if (match_pos_q < 4'd8) begin
								match_pos_d = match_pos_q + 4'd1;
							end
						end
					end
					PH_T_BODY: begin
						if (line_byte == CH_QUOTE) begin
							if (topic_count_q[8]) begin
								first_error_d = ST_INVALID;
							end else begin
								phase_d = PH_C_T;
							end
						end else if (bad_quoted(line_byte)) begin
							first_error_d = ST_INVALID;
						end else if (!topic_count_q[8]) begin
							topic_count_d = topic_count_q + 9'd1;
						end
					end
					PH_C_KIND, PH_C_N1, PH_C_N2, PH_C_T, PH_C_N3, PH_C_N4: begin
						if (!is_ws(line_byte)) begin
							if (line_byte == CH_COMMA) begin
								phase_d = phase_t'(phase_q << 1);
							end else begin
								first_error_d = ST_INVALID;
							end
						end
					end
					PH_N1_PRE, PH_N2_PRE, PH_N3_PRE, PH_N4_PRE: begin
						if (!is_ws(line_byte)) begin
							if (is_digit(line_byte)) begin
								number_acc_d = {28'd0, line_byte[3:0]};
								phase_d = phase_t'(phase_q << 1);
							end else begin
								first_error_d = ST_INVALID;
							end
						end
					end
					PH_N1_DIG, PH_N2_DIG, PH_N3_DIG, PH_N4_DIG: begin
						if (is_digit(line_byte)) begin
							// A further digit must keep the value within 32 bits.
							if ((number_acc_q > NUM_LIMIT) || ((number_acc_q == NUM_LIMIT) &&
							    (line_byte[3:0] > NUM_LIMIT_DIGIT))) begin
								first_error_d = ST_INVALID;
							end else begin
								number_acc_d = (number_acc_q << 3) + (number_acc_q << 1) +
									{28'd0, line_byte[3:0]};
							end
						end else if (is_ws(line_byte) || (line_byte == CH_COMMA)) begin
							if ((phase_q == PH_N1_DIG) && (number_acc_q != 32'd0)) begin
								first_error_d = ST_INVALID;
							end else begin
								if (phase_q == PH_N3_DIG) begin
									total_acc_d = number_acc_q;
								end
								if (phase_q == PH_N4_DIG) begin
									chunk_acc_d = number_acc_q;
								end
								if (line_byte == CH_COMMA) begin
									phase_d = phase_t'(phase_q << 2);
								end else begin
									phase_d = phase_t'(phase_q << 1);
								end
							end
						end else begin
							first_error_d = ST_INVALID;
						end
					end
					PH_PAYLOAD_WS: begin
						if (!is_ws(line_byte)) begin
							payload_start_d = idx;
							payload_count_d = 16'd1;
							phase_d = PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						if (payload_count_q < 16'hFFFF) begin
							payload_count_d = payload_count_q + 16'd1;
						end
					end
					default: begin
						first_error_d = ST_INVALID;
					end
				endcase
			end
		end
	end

	// Line verdict, valid on the byte that ends the line.
	always_comb begin
		result = '0;
		if (phase_d == PH_PAYLOAD) begin
			p_off  = payload_start_d;
			p_size = payload_count_d - crlf_run_d;
		end else begin
			p_off  = byte_index_d - crlf_run_d;
			p_size = 16'd0;
		end
		if (overlong_d || (byte_index_d < MIN_LINE)) begin
			result.status = ST_INVALID;
		end else if (first_error_d != 2'd0) begin
			result.status = status_t'(first_error_d);
		end else if ((phase_d != PH_PAYLOAD_WS) && (phase_d != PH_PAYLOAD)) begin
			result.status = ST_INVALID;
		end else if ((chunk_acc_d != {16'd0, p_size}) || (total_acc_d < chunk_acc_d)) begin
			result.status = ST_INVALID;
		end else begin
			result.status         = (total_acc_d != chunk_acc_d) ? ST_FRAGMENTED : ST_COMPLETE;
			result.topic_offset   = topic_start_d;
			result.topic_size     = topic_count_d[7:0];
			result.payload_offset = p_off;
			result.payload_size   = p_size;
			result.total_size     = total_acc_d;
		end
	end

	// Line state registers; the last byte of a line clears them for the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_PREFIX;
			byte_index_q    <= '0;
			match_pos_q     <= '0;
			kind_mismatch_q <= 1'b0;
			first_error_q   <= '0;
			number_acc_q    <= '0;
			total_acc_q     <= '0;
			chunk_acc_q     <= '0;
			topic_start_q   <= '0;
			topic_count_q   <= '0;
			payload_start_q <= '0;
			payload_count_q <= '0;
			crlf_run_q      <= '0;
			overlong_q      <= 1'b0;
		end else if (step && end_of_line) begin
			phase_q         <= PH_PREFIX;
			byte_index_q    <= '0;
			match_pos_q     <= '0;
			kind_mismatch_q <= 1'b0;
			first_error_q   <= '0;
			number_acc_q    <= '0;
			total_acc_q     <= '0;
			chunk_acc_q     <= '0;
			topic_start_q   <= '0;
			topic_count_q   <= '0;
			payload_start_q <= '0;
			payload_count_q <= '0;
			crlf_run_q      <= '0;
			overlong_q      <= 1'b0;
		end else if (step) begin
			phase_q         <= phase_d;
			byte_index_q    <= byte_index_d;
			match_pos_q     <= match_pos_d;
			kind_mismatch_q <= kind_mismatch_d;
			first_error_q   <= first_error_d;
			number_acc_q    <= number_acc_d;
			total_acc_q     <= total_acc_d;
			chunk_acc_q     <= chunk_acc_d;
			topic_start_q   <= topic_start_d;
			topic_count_q   <= topic_count_d;
			payload_start_q <= payload_start_d;
			payload_count_q <= payload_count_d;
			crlf_run_q      <= crlf_run_d;
			overlong_q      <= overlong_d;
		end
	end

	// A finished line leaves the parser ready for a fresh prefix.
	`MQPL_ASSERT_NEXT(a_line_clears, step && end_of_line, (byte_index_q == 16'd0) && (phase_q == PH_PREFIX), "line state not cleared after last byte")
	// Once an error is latched it holds until the line ends.
	`MQPL_ASSERT_NEXT(a_error_sticks, step && !end_of_line && (first_error_q != 2'd0), first_error_q == $past(first_error_q), "latched error changed within a line")
	// The topic counter saturates and never runs past 256.
	`MQPL_ASSERT_NOW(a_topic_sat, 1'b1, topic_count_q <= 9'd256, "topic count beyond saturation")

endmodule

`default_nettype wire

// ----- sv/mqpl_out.sv -----
`default_nettype none

module mqpl_out
	import mqpl_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t result_in,
	output logic         free,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      result_out
);

	logic    valid_q;
	result_t result_q;

	// The register can take a new result when empty or when its result leaves this cycle.
	assign free       = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign result_out = result_q;

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

endmodule

`default_nettype wire

// ----- sv/mqtt_publish_line_parser.sv -----
// Channel    Direction  Ports                        Contents
// s_*        in         s_tvalid s_tready s_tdata    line_byte; s_tlast is end_of_line
// m_*        out        m_tvalid m_tready m_tdata    one result per line
//
// One byte is accepted per cycle when the output side keeps up.
// A byte passes an input register, then the parser updates its line state.
// The line result appears on m_* at the same edge at which its last byte leaves the
// input register; a last byte waits there while the result register is still full.
// Reset is asynchronous and clears the line state and both valid flags.
`default_nettype none

module mqtt_publish_line_parser
	import mqpl_pkg::*;
#(
	parameter int MAX_LINE_BYTES = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] line_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata    // [1:0] status, [17:2] topic_offset,
	                                    // [25:18] topic_size, [41:26] payload_offset,
	                                    // [57:42] payload_size, [89:58] total_size,
	                                    // [95:90] zero
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       out_free;
	result_t    line_result;
	result_t    out_result;

	// The held byte moves on unless it closes a line and the result register is occupied.
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	mqpl_parse #(
		.MAX_LINE_BYTES(MAX_LINE_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.line_byte  (byte_s1),
		.end_of_line(last_s1),
		.result     (line_result)
	);

	mqpl_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && last_s1),
		.result_in (line_result),
		.free      (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result_out(out_result)
	);

	// Pack the result fields from the lowest bit up.
	assign m_tdata = {6'd0, out_result.total_size, out_result.payload_size,
		out_result.payload_offset, out_result.topic_size, out_result.topic_offset,
		out_result.status};

endmodule

`default_nettype wire

// ----- tb/sv/mqtt_publish_line_parser_test.sv -----
module mqtt_publish_line_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mqpl_pkg::*;

	localparam int MAX_LINE_BYTES = 65535;
	localparam int QUIET_TAIL = 150;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_BYTES = 560;
	localparam int REPORT_CAP = 50;
	localparam logic [71:0] PREFIX_TEXT = "+MQTTURC:";
	localparam logic [55:0] KIND_TEXT = "publish";

	// One byte of a line waiting to be sent; hold makes the sender wait for every result first.
	typedef struct {
		logic [7:0] value;
		logic       last;
		logic       hold;
	} line_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;  // [7:0] line_byte
	logic        s_tlast = 1'b0;   // end_of_line
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;          // [1:0] status, [17:2] topic_offset, [25:18] topic_size,
	                               // [41:26] payload_offset, [57:42] payload_size,
	                               // [89:58] total_size

	line_item_t line_bytes[$];
	logic [7:0] line_buf[$];
	result_t    line_results[$];
	int         mismatches = 0;
	int         send_gap = 0;
	int         ready_gap = 0;
	int         stall_cycles = 0;
	logic       calm = 1'b0;

	// Line state of the expected behaviour.
	phase_t      stage;
	logic [15:0] line_pos;
	logic [3:0]  kind_pos;
	logic        kind_off;
	logic        err_set;
	status_t     err_code;
	logic [31:0] num_acc;
	logic [31:0] total_len;
	logic [31:0] chunk_len;
	logic [15:0] topic_at;
	logic [8:0]  topic_len;
	logic [15:0] payload_at;
	logic [15:0] payload_len;
	logic [15:0] crlf_tail;
	logic        too_long;

	mqtt_publish_line_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
	endfunction

	function automatic logic numeral(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic barred_in_quotes(input logic [7:0] b);
		return b == CH_BSLASH || b < CH_SPACE;
	endfunction

	task automatic clear_line_state();
		stage = PH_PREFIX;
		line_pos = '0;
		kind_pos = '0;
		kind_off = 1'b0;
		err_set = 1'b0;
		err_code = ST_COMPLETE;
		num_acc = '0;
		total_len = '0;
		chunk_len = '0;
		topic_at = '0;
		topic_len = '0;
		payload_at = '0;
		payload_len = '0;
		crlf_tail = '0;
		too_long = 1'b0;
	endtask

	task automatic flag(input status_t code);
		err_set = 1'b1;
		err_code = code;
	endtask

	// Advances the field parser by one byte of the line.
	task automatic parse_field_byte(input logic [7:0] b, input logic [15:0] idx);
		logic [3:0] d;
		logic       ok;
		d = b[3:0];
		case (stage)
			PH_PREFIX: begin
				if (idx > 16'd8 || b != PREFIX_TEXT[8 * (8 - idx) +: 8]) flag(ST_NOT_PUBLISH);
				else if (idx == 16'd8) stage = PH_KIND_OPEN;
			end
			PH_KIND_OPEN, PH_T_OPEN: begin
				if (!blank(b)) begin
					if (b != CH_QUOTE) begin
						flag(ST_INVALID);
					end else begin
						if (stage == PH_T_OPEN) begin
							topic_at = idx + 16'd1;
							topic_len = '0;
						end
						stage = phase_t'(stage << 1);
					end
				end
			end
			PH_KIND_BODY: begin
				if (b == CH_QUOTE) begin
					if (kind_off || kind_pos != 4'd7) flag(ST_NOT_PUBLISH);
					else stage = PH_C_KIND;
				end else if (barred_in_quotes(b)) begin
					flag(ST_INVALID);
				end else begin
					if (kind_pos >= 4'd7 || b != KIND_TEXT[8 * (6 - kind_pos) +: 8]) kind_off = 1'b1;
					if (kind_pos < 4'd8) kind_pos++;
				end
			end
			PH_T_BODY: begin
				if (b == CH_QUOTE) begin
					if (topic_len > 9'd255) flag(ST_INVALID);
					else stage = PH_C_T;
				end else if (barred_in_quotes(b)) begin
					flag(ST_INVALID);
				end else if (topic_len < 9'd256) begin
					topic_len++;
				end
			end
			PH_C_KIND, PH_C_N1, PH_C_N2, PH_C_T, PH_C_N3, PH_C_N4: begin
				if (!blank(b)) begin
					if (b == CH_COMMA) stage = phase_t'(stage << 1);
					else flag(ST_INVALID);
				end
			end
			PH_N1_PRE, PH_N2_PRE, PH_N3_PRE, PH_N4_PRE: begin
				if (!blank(b)) begin
					if (numeral(b)) begin
						num_acc = 32'(d);
						stage = phase_t'(stage << 1);
					end else begin
						flag(ST_INVALID);
					end
				end
			end
			PH_N1_DIG, PH_N2_DIG, PH_N3_DIG, PH_N4_DIG: begin
				if (numeral(b)) begin
					if (num_acc > NUM_LIMIT || (num_acc == NUM_LIMIT && d > NUM_LIMIT_DIGIT))
						flag(ST_INVALID);
					else
						num_acc = num_acc * 32'd10 + 32'(d);
				end else if (blank(b) || b == CH_COMMA) begin
					// The first number must be zero; the last two are the lengths.
					ok = 1'b1;
					if (stage == PH_N1_DIG) ok = (num_acc == '0);
					if (stage == PH_N3_DIG) total_len = num_acc;
					if (stage == PH_N4_DIG) chunk_len = num_acc;
					if (!ok) flag(ST_INVALID);
					else if (b == CH_COMMA) stage = phase_t'(stage << 2);
					else stage = phase_t'(stage << 1);
				end else begin
					flag(ST_INVALID);
				end
			end
			PH_PAYLOAD_WS: begin
				if (!blank(b)) begin
					payload_at = idx;
					payload_len = 16'd1;
					stage = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (payload_len < 16'hFFFF) payload_len++;
			end
			default: flag(ST_INVALID);
		endcase
	endtask

	// Takes one accepted byte; on the last byte of a line it gives the line result.
	task automatic take_line_byte(input logic [7:0] b, input logic eol,
			output logic done, output result_t res);
		logic [15:0] idx;
		logic [15:0] len;
		logic [15:0] p_off;
		logic [15:0] p_size;
		done = 1'b0;
		res = '0;
		if (line_pos == 16'(MAX_LINE_BYTES)) begin
			too_long = 1'b1;
		end else begin
			idx = line_pos;
			line_pos = idx + 16'd1;
			if (b == CH_CR || b == CH_LF) crlf_tail++;
			else crlf_tail = '0;
			if (!err_set) parse_field_byte(b, idx);
		end
		if (eol) begin
			done = 1'b1;
			len = line_pos;
			if (too_long || len < MIN_LINE) begin
				res.status = ST_INVALID;
			end else if (err_set) begin
				res.status = err_code;
			end else if (stage != PH_PAYLOAD_WS && stage != PH_PAYLOAD) begin
				res.status = ST_INVALID;
			end else begin
				if (stage == PH_PAYLOAD) begin
					p_off = payload_at;
					p_size = payload_len - crlf_tail;
				end else begin
					p_off = len - crlf_tail;
					p_size = '0;
				end
				if (chunk_len != 32'(p_size) || total_len < chunk_len) begin
					res.status = ST_INVALID;
				end else begin
					res.status = (total_len != chunk_len) ? ST_FRAGMENTED : ST_COMPLETE;
					res.topic_offset = topic_at;
					res.topic_size = topic_len[7:0];
					res.payload_offset = p_off;
					res.payload_size = p_size;
					res.total_size = total_len;
				end
			end
			clear_line_state();
		end
	endtask

	// Line building.
	task automatic add_byte(input logic [7:0] b);
		line_buf.push_back(b);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	task automatic flush_line(input logic hold);
		for (int i = 0; i < line_buf.size(); i++)
			line_bytes.push_back('{line_buf[i], i == line_buf.size() - 1, hold && i == 0});
		line_buf.delete();
	endtask

	task automatic add_line(input string s, input logic hold);
		add_text(s);
		flush_line(hold);
	endtask

	// Optional whitespace between fields.
	task automatic add_gap();
		int n;
		n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: add_byte(CH_SPACE);
				1: add_byte(CH_TAB);
				2: add_byte(CH_CR);
				default: add_byte(CH_LF);
			endcase
		end
	endtask

	function automatic logic [31:0] pick_number();
		case ($urandom_range(0, 5))
			0: return 32'hFFFF_FFFF;
			1: return 32'hFFFF_FFFF - $urandom_range(0, 9);
			2: return $urandom();
			default: return $urandom_range(0, 999);
		endcase
	endfunction

	task automatic add_number(input logic [31:0] v);
		if ($urandom_range(0, 7) == 0) add_byte(8'h30);
		add_text($sformatf("%0d", v));
	endtask

	// A publish line with random spacing, numbers, topic and payload.
	task automatic add_publish_line(input string kind);
		int         topic_n;
		int         body_n;
		logic [31:0] chunk_n;
		logic [31:0] total_n;
		logic [7:0] c;
		add_text("+MQTTURC:");
		add_gap();
		add_text({"\"", kind, "\""});
		add_gap();
		add_byte(CH_COMMA);
		add_gap();
		add_text(($urandom_range(0, 3) == 0) ? "00" : "0");
		add_gap();
		add_byte(CH_COMMA);
		add_gap();
		add_number(pick_number());
		add_gap();
		add_byte(CH_COMMA);
		add_gap();
		add_byte(CH_QUOTE);
		case ($urandom_range(0, 39))
			0: topic_n = 255;
			1: topic_n = 256;
			default: topic_n = $urandom_range(0, 12);
		endcase
		repeat (topic_n) begin
			do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
			add_byte(c);
		end
		add_byte(CH_QUOTE);
		add_gap();
		add_byte(CH_COMMA);
		add_gap();
		body_n = $urandom_range(0, 24);
		chunk_n = body_n;
		case ($urandom_range(0, 1))
			0: total_n = chunk_n;
			default: total_n = chunk_n + (($urandom_range(0, 3) == 0) ?
				$urandom_range(0, 32'hFFFF_FFFF - chunk_n) : $urandom_range(1, 500));
		endcase
		// Occasional length disagreements.
		case ($urandom_range(0, 11))
			0: chunk_n = chunk_n + 1;
			1: if (chunk_n != 0) chunk_n = chunk_n - 1;
			2: if (chunk_n != 0) total_n = chunk_n - 1;
			default: ;
		endcase
		add_number(total_n);
		add_gap();
		add_byte(CH_COMMA);
		add_gap();
		add_number(chunk_n);
		add_gap();
		add_byte(CH_COMMA);
		add_gap();
		for (int i = 0; i < body_n; i++) begin
			c = 8'($urandom_range(0, 255));
			if (i == 0 && blank(c)) c = 8'h78;
			if (i == body_n - 1 && (c == CH_CR || c == CH_LF)) c = 8'h79;
			add_byte(c);
		end
		repeat ($urandom_range(0, 2)) add_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
	endtask

	function automatic string pick_kind();
		case ($urandom_range(0, 24))
			0: return "publisx";
			1: return "publishh";
			2: return "pub";
			3: return "pu\\lish";
			default: return "publish";
		endcase
	endfunction

	// Breaks a line by overwriting, inserting or cutting.
	task automatic damage_line();
		int at;
		at = $urandom_range(0, line_buf.size() - 1);
		case ($urandom_range(0, 2))
			0: line_buf[at] = 8'($urandom_range(0, 255));
			1: line_buf.insert(at, 8'($urandom_range(0, 255)));
			default: while (line_buf.size() > at + 1) void'(line_buf.pop_back());
		endcase
	endtask

	task automatic add_noise_line();
		if ($urandom_range(0, 2) == 0) add_text("+MQTTURC:");
		repeat ($urandom_range(1, 40)) add_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic add_topic_line(input int topic_n);
		add_text("+MQTTURC:\"publish\",0,0,\"");
		repeat (topic_n) add_byte(8'($urandom_range(33, 126)) == CH_BSLASH ? 8'h61 : 8'h62);
		add_text("\",2,2,ok");
		flush_line(1'b0);
	endtask

	// Sender: presents the pending bytes and tracks each accepted one.
	always @(posedge clk) begin : feed
		logic    done;
		result_t res;
		logic    show;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				take_line_byte(s_tdata, s_tlast, done, res);
				if (done) line_results.push_back(res);
				void'(line_bytes.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				show = 1'b0;
				if (send_gap != 0) begin
					send_gap--;
				end else if (line_bytes.size() != 0 &&
						!(line_bytes[0].hold && line_results.size() != 0)) begin
					if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(0, 18);
					else show = 1'b1;
				end
				s_tvalid <= show;
				if (show) begin
					s_tdata <= line_bytes[0].value;
					s_tlast <= line_bytes[0].last;
				end
			end
			calm <= line_bytes.size() < QUIET_TAIL;
		end
	end

	task automatic compare_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < REPORT_CAP)
				$display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Receiver: checks each result against the oldest expected one.
	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (line_results.size() == 0) begin
					if (mismatches < REPORT_CAP)
						$display("%0t: result expected none, actual %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = line_results.pop_front();
					compare_field("status", 32'(want.status), 32'(m_tdata[1:0]));
					compare_field("topic_offset", 32'(want.topic_offset), 32'(m_tdata[17:2]));
					compare_field("topic_size", 32'(want.topic_size), 32'(m_tdata[25:18]));
					compare_field("payload_offset", 32'(want.payload_offset), 32'(m_tdata[41:26]));
					compare_field("payload_size", 32'(want.payload_size), 32'(m_tdata[57:42]));
					compare_field("total_size", want.total_size, m_tdata[89:58]);
				end
			end
			if (ready_gap != 0) begin
				ready_gap--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				ready_gap = $urandom_range(0, 18);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which neither side moves a request.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		int random_count;
		int r;
		// Reset goes low once every process waits on its clock and reset edges.
		arst_n <= 1'b0;
		clear_line_state();

		// Directed lines.
		add_line("+MQT", 1'b1);
		add_line("+MQTTURC:", 1'b0);
		add_line("+MQTTURX:\"publish\",0,0,\"\",0,0,", 1'b0);
		add_line("+MQTTURC: \"connect\",0,0", 1'b0);
		add_line("+MQTTURC:\"publishx\",0", 1'b0);
		add_line("+MQTTURC:\"publis\",0,0,\"\",0,0,", 1'b1);
		add_line("+MQTTURC:\"pu\\lish\",0", 1'b0);
		add_line("+MQTTURC:\"publish\",0,0,\"\",0,0,", 1'b0);
		add_line("+MQTTURC: \"publish\" , 0 , 7 , \"a/b\" , 5 , 5 ,\thello\r\n", 1'b0);
		add_line("+MQTTURC:\"publish\",0,4294967295,\"t\",4294967295,3,abc", 1'b0);
		add_line("+MQTTURC:\"publish\",1,0,\"\",0,0,", 1'b0);
		add_line("+MQTTURC:\"publish\",0,4294967296,\"\",0,0,", 1'b0);
		add_line("+MQTTURC:\"publish\",0,42949672950,\"\",0,0,", 1'b0);
		add_line("+MQTTURC:\"publish\",0,0,\"t\",2,3,abc", 1'b0);
		add_line("+MQTTURC:\"publish\",0,0,\"t\",4,4,abc", 1'b0);
		add_line("+MQTTURC:\"publish\",0,0,\"a\\b\",1,1,x", 1'b0);
		add_text("+MQTTURC:\"publish\",0,0,\"a");
		add_byte(8'h01);
		add_line("\",1,1,x", 1'b0);
		add_line("+MQTTURC:\"publish\",0,0,\"top", 1'b0);
		add_line("+MQTTURC:\"publish\",0,0,\"\",0,0,\r\n", 1'b0);
		add_line("+MQTTURC:\"publish\";0", 1'b0);
		add_line("+MQTTURC:\"publish\",0x,0", 1'b0);
		add_topic_line(255);
		add_topic_line(256);

		// Random lines: mostly well formed, the rest damaged or noise.
		random_count = 0;
		while (random_count < RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				add_publish_line(pick_kind());
			end else if (r < 90) begin
				add_publish_line("publish");
				damage_line();
			end else begin
				add_noise_line();
			end
			random_count += line_buf.size();
			flush_line($urandom_range(0, 9) == 0);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (line_bytes.size() == 0 && line_results.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && line_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- mqtt_publish_line_parser.f -----
+incdir+sv
sv/mqpl_pkg.sv
sv/mqpl_parse.sv
sv/mqpl_out.sv
sv/mqtt_publish_line_parser.sv
tb/sv/mqtt_publish_line_parser_test.sv
